@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a same-cycle implication on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("port check failed");

// Check an implication whose consequent is due in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

@@ rtl/dhoe_pkg.sv @@
package dhoe_pkg;

  // Frame layout: Ethernet header, fixed 20-byte IP header, 8-byte UDP header
  localparam logic [15:0] MAC_FIRST_POS = 16'd6;
  localparam logic [15:0] MAC_END_POS   = 16'd12;
  localparam logic [15:0] ETYPE_HI_POS  = 16'd12;
  localparam logic [15:0] ETYPE_LO_POS  = 16'd13;
  localparam logic [15:0] UDP_LEN_POS   = 16'd38;
  localparam logic [15:0] PAYLOAD_START = 16'd42;

  // DHCP options begin after 236 fixed bytes and the 4-byte cookie
  localparam logic [15:0] OPT_START     = 16'd240;
  localparam logic [15:0] SKIP_SAT      = 16'hFFFF;

  localparam logic [7:0]  ETYPE_HI      = 8'h08;
  localparam logic [7:0]  ETYPE_LO      = 8'h00;
  localparam logic [7:0]  OPT_PAD       = 8'd0;
  localparam logic [7:0]  OPT_END       = 8'd255;
  localparam logic [7:0]  OPT_CODE_RST  = 8'd12;

  // Result status codes
  localparam logic [1:0]  ST_OK         = 2'd0;
  localparam logic [1:0]  ST_EARLY      = 2'd1;
  localparam logic [1:0]  ST_CUT        = 2'd2;

  // Result queue depth
  localparam int          Q_DEPTH       = 4;

  typedef struct packed {
    logic [7:0]  name_byte;
    logic        byte_valid;
    logic [47:0] source_mac;
    logic        name_last;
    logic [1:0]  name_status;
  } result_t;

endpackage

@@ rtl/dhoe_front.sv @@
module dhoe_front import dhoe_pkg::*; #(
  parameter int MAX_NAME_LEN   = 63,
  parameter int POSITION_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    frame_byte,
  input  logic          frame_end,
  input  logic          cfg_valid,
  input  logic [7:0]    cfg_data,
  input  logic          q_full,
  output logic          res_valid,
  output result_t       res
);

  localparam logic [2:0] PH_TAG       = 3'd0;
  localparam logic [2:0] PH_LEN_SKIP  = 3'd1;
  localparam logic [2:0] PH_LEN_MATCH = 3'd2;
  localparam logic [2:0] PH_NAME      = 3'd3;
  localparam logic [2:0] PH_DONE      = 3'd4;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
  localparam logic [7:0] NAME_MAX = 8'(MAX_NAME_LEN);

  logic [POSITION_WIDTH-1:0] pos, pos_next;
  logic [2:0]                phase, phase_next;
  logic [47:0]               mac, mac_next;
  logic                      eth_ok, eth_ok_next;
  logic [15:0]               udp_len, udp_len_next;
  logic [15:0]               tag_pos, tag_pos_next;
  logic [7:0]                opt_rem, opt_rem_next;
  logic [7:0]                name_cnt, name_cnt_next;
  logic [7:0]                opt_code;

  logic        fire;
  logic        active;
  logic [15:0] p;
  logic [15:0] d;
  logic [16:0] skip_tgt;
  logic [7:0]  rem_dec;
  logic [7:0]  cnt_inc;
  logic        emitted;
  logic        last;
  logic [1:0]  status;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign active   = (pos != POS_MAX);
  assign p        = 16'(pos);
  assign d        = p - PAYLOAD_START;
  assign skip_tgt = {1'b0, d} + 17'd1 + 17'(frame_byte);
  assign rem_dec  = opt_rem - 8'd1;
  assign cnt_inc  = name_cnt + 8'd1;

  // Parse one frame byte: header capture and option walk
  always_comb begin
    pos_next      = pos;
    phase_next    = phase;
    mac_next      = mac;
    eth_ok_next   = eth_ok;
    udp_len_next  = udp_len;
    tag_pos_next  = tag_pos;
    opt_rem_next  = opt_rem;
    name_cnt_next = name_cnt;
    emitted       = 1'b0;
    last          = 1'b0;
    status        = ST_OK;
    if (active) begin
      pos_next = pos + 1'b1;
      if (p >= MAC_FIRST_POS && p < MAC_END_POS) begin
        mac_next = {mac[39:0], frame_byte};
      end
      if (p == ETYPE_HI_POS) begin
        eth_ok_next = (frame_byte == ETYPE_HI);
      end
      if (p == ETYPE_LO_POS) begin
        eth_ok_next = eth_ok && (frame_byte == ETYPE_LO);
      end
      if (p == UDP_LEN_POS) begin
        udp_len_next = {frame_byte, udp_len[7:0]};
      end
      if (p == UDP_LEN_POS + 16'd1) begin
        udp_len_next = {udp_len[15:8], frame_byte};
      end
      if (eth_ok && p >= PAYLOAD_START) begin
        case (phase)
          PH_TAG: begin
            if (d == tag_pos) begin
              if (d >= udp_len || frame_byte == OPT_END) begin
                phase_next = PH_DONE;
              end else if (frame_byte == OPT_PAD) begin
                tag_pos_next = d + 16'd1;
              end else if (frame_byte == opt_code) begin
                phase_next = PH_LEN_MATCH;
              end else begin
                phase_next = PH_LEN_SKIP;
              end
            end
          end
          PH_LEN_SKIP: begin
            tag_pos_next = skip_tgt[16] ? SKIP_SAT : skip_tgt[15:0];
            phase_next   = PH_TAG;
          end
          PH_LEN_MATCH: begin
            if (frame_byte == 8'd0) begin
              phase_next = PH_DONE;
            end else begin
              opt_rem_next  = frame_byte;
              name_cnt_next = 8'd0;
              phase_next    = PH_NAME;
            end
          end
          PH_NAME: begin
            emitted       = 1'b1;
            name_cnt_next = cnt_inc;
            opt_rem_next  = rem_dec;
            if (rem_dec == 8'd0) begin
              last       = 1'b1;
              phase_next = PH_DONE;
            end else if (cnt_inc >= NAME_MAX) begin
              last       = 1'b1;
              status     = ST_CUT;
              phase_next = PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
    // Frame ended inside the value: mark the byte, or give a status-only beat
    if (emitted && !last && frame_end) begin
      last   = 1'b1;
      status = ST_EARLY;
    end
  end

  // Form the result beat for the queue
  always_comb begin
    res.name_byte   = emitted ? frame_byte : 8'd0;
    res.byte_valid  = emitted;
    res.source_mac  = mac_next;
    res.name_last   = emitted ? last : 1'b1;
    res.name_status = emitted ? status : ST_EARLY;
    res_valid       = fire && (emitted ||
                      (frame_end && (phase_next == PH_LEN_MATCH || phase_next == PH_NAME)));
  end

  // Hold parse state; clear it on reset and after the last byte of each frame
  always_ff @(posedge clk) begin
    if (rst || (fire && frame_end)) begin
      pos      <= '0;
      phase    <= PH_TAG;
      mac      <= '0;
      eth_ok   <= 1'b0;
      udp_len  <= '0;
      tag_pos  <= OPT_START;
      opt_rem  <= '0;
      name_cnt <= '0;
    end else if (fire) begin
      pos      <= pos_next;
      phase    <= phase_next;
      mac      <= mac_next;
      eth_ok   <= eth_ok_next;
      udp_len  <= udp_len_next;
      tag_pos  <= tag_pos_next;
      opt_rem  <= opt_rem_next;
      name_cnt <= name_cnt_next;
    end
  end

  // Option code register
  always_ff @(posedge clk) begin
    if (rst) begin
      opt_code <= OPT_CODE_RST;
    end else if (cfg_valid) begin
      opt_code <= cfg_data;
    end
  end

endmodule

@@ rtl/dhoe_queue.sv @@
module dhoe_queue import dhoe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output result_t head
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam logic [PW:0] DEPTH_CNT = (PW + 1)'(Q_DEPTH);

  result_t       entries [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full      = (count == DEPTH_CNT);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/dhoe_back.sv @@
module dhoe_back import dhoe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_not_empty,
  input  result_t     q_head,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  output logic [0:0]  m_tuser,
  output logic        m_tlast
);

  result_t out_res;
  logic    load;

  assign load  = q_not_empty && (!m_tvalid || m_tready);
  assign q_pop = load;

  // Output register: refill from the queue whenever it is empty or the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= q_head;
    end
  end

  // Pack the result beat
  assign m_tdata = {6'd0, out_res.name_status, out_res.source_mac, out_res.name_byte};
  assign m_tuser = out_res.byte_valid;
  assign m_tlast = out_res.name_last;

endmodule

@@ rtl/dhcp_hostname_option_extractor.sv @@
// Extracts the value of one DHCP option from Ethernet frames delivered one byte per beat
// (tlast on the final byte). IPv4 frames with a 20-byte IP header are walked from the
// DHCP options onward; the first option matching the code written on the cfg channel
// (12, the hostname, after reset) has its value bytes sent out one per beat together
// with the frame's source MAC, tlast on the final one and a status: 0 complete,
// 1 frame ended early, 2 cut at MAX_NAME_LEN bytes. A frame that ends right after the
// matching tag or its nonzero length byte gives one status-only beat (tuser 0). The block
// takes one byte per cycle while the result queue has room. A byte's result is queued
// when the byte is accepted and later loaded into the output register. A four-beat
// result queue between the parser and the output register absorbs downstream stalls,
// and input is held off only while that queue is full. Write cfg only between frames.
module dhcp_hostname_option_extractor import dhoe_pkg::*; #(
  parameter int MAX_NAME_LEN   = 63,
  parameter int POSITION_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] frame_byte
  input  logic        s_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [7:0] name_byte, [55:8] source_mac, [57:56] name_status
  output logic [0:0]  m_tuser,   // [0] byte_valid
  output logic        m_tlast
);

  result_t fr_res;
  result_t q_head;
  logic    fr_valid;
  logic    q_full;
  logic    q_not_empty;
  logic    q_pop;

  assign cfg_ready = 1'b1;

  dhoe_front #(
    .MAX_NAME_LEN   (MAX_NAME_LEN),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .frame_byte (s_tdata),
    .frame_end  (s_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .res_valid  (fr_valid),
    .res        (fr_res)
  );

  dhoe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fr_valid),
    .push_data (fr_res),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  dhoe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

@@ rtl/dhoe_checker.sv @@
`include "assert_macros.svh"

module dhoe_checker import dhoe_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  logic [1:0] st;
  logic [7:0] nbyte;
  logic       status_only;

  assign st          = m_tdata[57:56];
  assign nbyte       = m_tdata[7:0];
  assign status_only = m_tvalid && !m_tuser[0];

  // A stalled beat stays and keeps its payload
  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // A status-only beat closes the name and carries a zero byte with early-end status
  `ASSERT_IMPLY(a_status_only, clk, rst, status_only, m_tlast && nbyte == 8'd0 && st == ST_EARLY)
  // Only the closing beat carries a nonzero status
  `ASSERT_IMPLY(a_mid_status, clk, rst, m_tvalid && !m_tlast, st == ST_OK)
  // Status code and pad bits stay in range
  `ASSERT_IMPLY(a_status_range, clk, rst, m_tvalid, st <= ST_CUT && m_tdata[63:58] == 6'd0)

endmodule

bind dhcp_hostname_option_extractor dhoe_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ verif/dhcp_hostname_option_extractor_tb.sv @@
`timescale 1ns / 100ps

module dhcp_hostname_option_extractor_tb;
  import dhoe_pkg::*;

  localparam int NAME_MAX = 63;
  localparam int POS_W = 16;
  localparam logic [15:0] POS_TOP = 16'hFFFF;
  localparam logic [15:0] ETHERTYPE_IP = {ETYPE_HI, ETYPE_LO};
  localparam logic [15:0] UDP_BIG = 16'd1500;
  localparam int NO_CHECK = -1;
  localparam int SETTLE = 8;
  localparam int NUM_ROWS = 23;

  typedef enum logic [2:0] {W_TAG, W_LEN_SKIP, W_LEN_MATCH, W_VALUE, W_DONE} walk_t;

  // One directed frame: layout knobs plus the outcome typed in where obvious
  typedef struct packed {
    logic [7:0]  code;     // option code register for this frame
    logic [15:0] ety;
    logic [15:0] udp;
    int          pads;     // pad options ahead of the rest
    int          skip;     // length of a non-matching option, -1 for none
    logic [7:0]  tag;      // tag of the option after that
    int          vlen;     // its length byte
    int          stop;     // end the frame this many bytes after the tag, -1 for full
    int          trunc;    // absolute frame length, 0 for none
    int          want_n;
    int          want_st;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] frame_byte
  logic        s_tlast = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;           // [7:0] name_byte, [55:8] source_mac, [57:56] name_status
  logic [0:0]  m_tuser;           // [0] byte_valid
  logic        m_tlast;

  dhcp_hostname_option_extractor #(
    .MAX_NAME_LEN(NAME_MAX),
    .POSITION_WIDTH(POS_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Parser copy kept by the testbench
  logic [15:0] pos;
  walk_t       walk;
  logic [47:0] src_mac;
  logic        ipv4_ok;
  logic [15:0] udp_len_r;
  logic [15:0] tag_at;
  logic [7:0]  value_left;
  logic [7:0]  value_count;
  logic [7:0]  cur_code = OPT_CODE_RST;

  result_t     pending_names[$];
  logic [7:0]  frame_q[$];
  bit          gaps_on = 1'b1;
  int          miss_count = 0;
  int          beats_seen = 0;
  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          cfg_writes = 0;
  int          frame_hits;
  int          frame_last_st;
  int          stall_left = 0;

  frame_row_t plan [NUM_ROWS] = '{
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_CODE_RST, 5, -1, 0, 5, ST_OK},
    '{OPT_CODE_RST, 16'h86DD, UDP_BIG, 0, -1, OPT_CODE_RST, 5, -1, 0, 0, NO_CHECK},
    '{OPT_CODE_RST, 16'h0801, UDP_BIG, 0, -1, OPT_CODE_RST, 5, -1, 0, 0, NO_CHECK},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_CODE_RST, 5, -1, 30, 0, NO_CHECK},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_CODE_RST, 5, -1, 1, 0, NO_CHECK},
    '{OPT_CODE_RST, ETHERTYPE_IP, 16'd240, 0, -1, OPT_CODE_RST, 5, -1, 0, 0, NO_CHECK},
    '{OPT_CODE_RST, ETHERTYPE_IP, 16'd241, 0, -1, OPT_CODE_RST, 5, -1, 0, 5, ST_OK},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 3, 7, OPT_CODE_RST, 8, -1, 0, 8, ST_OK},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 0, 0, OPT_CODE_RST, 4, -1, 0, 4, ST_OK},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_CODE_RST, 0, -1, 0, 0, NO_CHECK},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_CODE_RST, 63, -1, 0, 63, ST_OK},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_CODE_RST, 64, -1, 0, 63, ST_CUT},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 1, 2, OPT_CODE_RST, 255, -1, 0, 63, ST_CUT},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_CODE_RST, 6, 0, 0, 1, ST_EARLY},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_CODE_RST, 6, 1, 0, 1, ST_EARLY},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_CODE_RST, 0, 1, 0, 0, NO_CHECK},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_CODE_RST, 10, 4, 0, 3, ST_EARLY},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_CODE_RST, 5, 6, 0, 5, ST_OK},
    '{OPT_CODE_RST, ETHERTYPE_IP, UDP_BIG, 2, -1, OPT_END, 5, -1, 0, 0, NO_CHECK},
    '{8'd1, ETHERTYPE_IP, UDP_BIG, 0, 3, 8'd1, 4, -1, 0, 4, ST_OK},
    '{8'd254, ETHERTYPE_IP, UDP_BIG, 0, -1, 8'd254, 2, -1, 0, 2, ST_OK},
    '{OPT_PAD, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_PAD, 3, -1, 0, 0, NO_CHECK},
    '{OPT_END, ETHERTYPE_IP, UDP_BIG, 0, -1, OPT_END, 3, -1, 0, 0, NO_CHECK}
  };

  task automatic report_miss(input string what, input longint got, input longint want);
    if (miss_count < 40)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    miss_count++;
  endtask

  task automatic restart_walk();
    pos = '0;
    walk = W_TAG;
    src_mac = '0;
    ipv4_ok = 1'b0;
    udp_len_r = '0;
    tag_at = OPT_START;
    value_left = '0;
    value_count = '0;
  endtask

  // Advance the parser copy by one frame byte and queue any name beat it causes
  task automatic parse_byte(input logic [7:0] b, input logic fin);
    logic [15:0] p;
    logic [15:0] d;
    logic [16:0] tgt;
    logic        hit;
    logic        eol;
    logic [1:0]  st;
    result_t     nb;
    p = pos;
    hit = 1'b0;
    eol = 1'b0;
    st = ST_OK;
    if (p != POS_TOP) begin
      if (p >= MAC_FIRST_POS && p < MAC_END_POS) src_mac = {src_mac[39:0], b};
      if (p == ETYPE_HI_POS) ipv4_ok = (b == ETYPE_HI);
      if (p == ETYPE_LO_POS) ipv4_ok = ipv4_ok && (b == ETYPE_LO);
      if (p == UDP_LEN_POS) udp_len_r[15:8] = b;
      if (p == UDP_LEN_POS + 16'd1) udp_len_r[7:0] = b;
      if (ipv4_ok && p >= PAYLOAD_START) begin
        d = p - PAYLOAD_START;
        case (walk)
          W_TAG: begin
            if (d == tag_at) begin
              if (d >= udp_len_r || b == OPT_END) walk = W_DONE;
              else if (b == OPT_PAD) tag_at = d + 16'd1;
              else if (b == cur_code) walk = W_LEN_MATCH;
              else walk = W_LEN_SKIP;
            end
          end
          W_LEN_SKIP: begin
            tgt = {1'b0, d} + 17'd1 + {9'd0, b};
            tag_at = tgt[16] ? SKIP_SAT : tgt[15:0];
            walk = W_TAG;
          end
          W_LEN_MATCH: begin
            if (b == 8'd0) begin
              walk = W_DONE;
            end else begin
              value_left = b;
              value_count = '0;
              walk = W_VALUE;
            end
          end
          W_VALUE: begin
            hit = 1'b1;
            value_count = value_count + 8'd1;
            value_left = value_left - 8'd1;
            if (value_left == 8'd0) begin
              eol = 1'b1;
              walk = W_DONE;
            end else if (value_count >= NAME_MAX) begin
              eol = 1'b1;
              st = ST_CUT;
              walk = W_DONE;
            end
          end
          default: ;
        endcase
      end
      pos = p + 16'd1;
    end

    // Emit a value beat, or a status-only beat when the frame ends mid-option
    if (hit) begin
      if (!eol && fin) begin
        eol = 1'b1;
        st = ST_EARLY;
      end
      nb = '{name_byte: b, byte_valid: 1'b1, source_mac: src_mac, name_last: eol,
             name_status: st};
      pending_names.push_back(nb);
      frame_hits++;
      frame_last_st = st;
    end else if (fin && (walk == W_LEN_MATCH || walk == W_VALUE)) begin
      nb = '{name_byte: 8'd0, byte_valid: 1'b0, source_mac: src_mac, name_last: 1'b1,
             name_status: ST_EARLY};
      pending_names.push_back(nb);
      frame_hits++;
      frame_last_st = ST_EARLY;
    end
    if (fin) restart_walk();
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (gaps_on && $urandom_range(0, 15) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    parse_byte(b, fin);
  endtask

  // Build one frame from its layout knobs and stream it out
  task automatic send_frame(input frame_row_t r);
    int tag_pos;
    int n;
    logic [7:0] skip_tag;
    skip_tag = (r.code == 8'd50) ? 8'd51 : 8'd50;
    frame_q.delete();
    repeat (12) frame_q.push_back(8'($urandom));
    frame_q.push_back(r.ety[15:8]);
    frame_q.push_back(r.ety[7:0]);
    while (frame_q.size() < UDP_LEN_POS) frame_q.push_back(8'($urandom));
    frame_q.push_back(r.udp[15:8]);
    frame_q.push_back(r.udp[7:0]);
    while (frame_q.size() < PAYLOAD_START + OPT_START) frame_q.push_back(8'($urandom));
    repeat (r.pads) frame_q.push_back(OPT_PAD);
    if (r.skip >= 0) begin
      frame_q.push_back(skip_tag);
      frame_q.push_back(8'(r.skip));
      repeat (r.skip) frame_q.push_back(8'($urandom));
    end
    tag_pos = frame_q.size();
    frame_q.push_back(r.tag);
    frame_q.push_back(8'(r.vlen));
    repeat (r.vlen)
      frame_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
    frame_q.push_back(OPT_END);
    repeat (8) frame_q.push_back(8'($urandom));
    n = frame_q.size();
    if (r.stop >= 0) n = tag_pos + 1 + r.stop;
    if (r.trunc > 0) n = r.trunc;
    while (frame_q.size() > n) void'(frame_q.pop_back());

    frame_hits = 0;
    frame_last_st = NO_CHECK;
    foreach (frame_q[k]) send_byte(frame_q[k], k == frame_q.size() - 1);
    frames_sent++;
  endtask

  // Hold input until every queued name beat has come out, then let the pipe settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_names.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_code(input logic [7:0] c);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_code = c;
    cfg_writes++;
  endtask

  task automatic check_beat();
    result_t want;
    if (pending_names.size() == 0) begin
      report_miss("beat with nothing pending", m_tdata, 0);
      return;
    end
    want = pending_names.pop_front();
    if (m_tdata[7:0] != want.name_byte) report_miss("name_byte", m_tdata[7:0], want.name_byte);
    if (m_tuser[0] != want.byte_valid) report_miss("byte_valid", m_tuser[0], want.byte_valid);
    if (m_tdata[55:8] != want.source_mac)
      report_miss("source_mac", m_tdata[55:8], want.source_mac);
    if (m_tlast != want.name_last) report_miss("name_last", m_tlast, want.name_last);
    if (m_tdata[57:56] != want.name_status)
      report_miss("name_status", m_tdata[57:56], want.name_status);
    beats_seen++;
  endtask

  // Check output beats and stall the receiver in random bursts
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_beat();
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    #20_000_000;
    $display("dhcp_hostname_option_extractor_tb: FAIL");
    $finish;
  end

  initial begin
    frame_row_t r;
    int rnd_start;
    int rnd_beats;
    restart_walk();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames, typed outcomes checked against the parser copy
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (plan[i].code != cur_code) write_code(plan[i].code);
      send_frame(plan[i]);
      if (plan[i].want_n != NO_CHECK && frame_hits != plan[i].want_n)
        report_miss($sformatf("row %0d beat count", i), frame_hits, plan[i].want_n);
      if (plan[i].want_st != NO_CHECK && frame_last_st != plan[i].want_st)
        report_miss($sformatf("row %0d final status", i), frame_last_st, plan[i].want_st);
    end

    // Random frames: mostly well-formed DHCP with random options, some noise
    rnd_start = bytes_sent;
    rnd_beats = 0;
    while (bytes_sent - rnd_start < 1400 || rnd_beats < 48) begin
      if ($urandom_range(0, 4) == 0) write_code(8'($urandom_range(1, 254)));
      if (bytes_sent - rnd_start >= 1100) gaps_on = 1'b0;
      r.code = cur_code;
      r.ety = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETHERTYPE_IP;
      r.udp = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(600, 9000));
      r.pads = $urandom_range(0, 3);
      r.skip = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, 12);
      r.tag = ($urandom_range(0, 3) == 0) ? 8'($urandom) : cur_code;
      case ($urandom_range(0, 15))
        0:       r.vlen = $urandom_range(0, 255);
        1, 2:    r.vlen = $urandom_range(55, 80);
        default: r.vlen = $urandom_range(0, 20);
      endcase
      r.stop = ($urandom_range(0, 4) == 0) ? $urandom_range(0, r.vlen + 2) : -1;
      r.trunc = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 60) : 0;
      r.want_n = NO_CHECK;
      r.want_st = NO_CHECK;
      send_frame(r);
      rnd_beats += frame_hits;
    end

    // Drain and let the last beats out
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d frames (%0d bytes), %0d name beats checked, %0d code writes",
             frames_sent, bytes_sent, beats_seen, cfg_writes);
    $display("directed: bad ethertype, short frames, cut and early-ended names, odd codes");
    if (miss_count == 0 && pending_names.size() == 0) begin
      $display("dhcp_hostname_option_extractor_tb: PASS");
    end else begin
      $display("dhcp_hostname_option_extractor_tb: FAIL");
    end
    $finish;
  end

endmodule
